// ===== src/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 transcoder.
// Holds code constants, the result type and the lead byte decode.
// No dependencies.
package u8u16_pkg;

	localparam int unsigned CodeW    = 31;
	localparam int unsigned UnitW    = 16;
	localparam int unsigned PendW    = 3;

	localparam logic [UnitW-1:0] HiSurrBase = 16'hD800;
	localparam logic [UnitW-1:0] LoSurrBase = 16'hDC00;
	localparam logic [19:0]      SuppOffset = 20'h10000;

	typedef struct packed {
		logic [UnitW-1:0] unit;
		logic             last;
		logic             done;
		logic             trunc;
	} result_t;

	typedef struct packed {
		logic [CodeW-1:0] code;
		logic [PendW-1:0] pend;
	} lead_t;

	// Lead byte: payload bits and continuation count, old six-byte layout.
	function automatic lead_t decode_lead(input logic [7:0] b);
		lead_t r;
		r.code = '0;
		casez (b)
			8'b0???????: begin
				r.code[6:0] = b[6:0];
				r.pend      = 3'd0;
			end
			8'b110?????: begin
				r.code[4:0] = b[4:0];
				r.pend      = 3'd1;
			end
			8'b1110????: begin
				r.code[3:0] = b[3:0];
				r.pend      = 3'd2;
			end
			8'b11110???: begin
				r.code[2:0] = b[2:0];
				r.pend      = 3'd3;
			end
			8'b111110??: begin
				r.code[1:0] = b[1:0];
				r.pend      = 3'd4;
			end
			default: begin
				r.code[0] = b[0];
				r.pend    = 3'd5;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== src/utf8_to_utf16_transcoder_unit.sv =====
// Top level of the UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg for constants, the result type and lead decode.
//
// Usage: the input channel (in_valid/in_ready) takes one UTF-8 byte per
// request with end_of_text marking the final byte. The output channel
// (out_valid/out_ready) gives UTF-16 units with last_of_run, text_done and
// truncated. A byte is decoded in the cycle it is accepted and its first
// unit is registered into the output register. Bytes are taken at one per
// clock while the output is free; a byte that closes a supplementary code
// yields a surrogate pair, and the second half sits in a holding register,
// so the input is held off until that half moves on. Bytes that complete
// nothing produce no output unless marked end_of_text, which yields a
// truncated result. in_ready follows out_ready in the same cycle when the
// output register is full and the holding register is empty.
// Reset clears the partial code, pending count and both valid flags.
// When the receiver stalls, the output holds and input stops once the
// output register cannot be freed.
module utf8_to_utf16_transcoder_unit
	import u8u16_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       text_byte,
	input  logic             end_of_text,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [UnitW-1:0] code_unit,
	output logic             last_of_run,
	output logic             text_done,
	output logic             truncated
);

	logic [CodeW-1:0] partial_q;
	logic [PendW-1:0] pend_q;
	logic             out_valid_q;
	result_t          out_q;
	logic             hold_valid_q;
	result_t          hold_q;

	logic             in_fire;
	logic             out_free;
	lead_t            lead;
	logic [CodeW-1:0] code_nx;
	logic [PendW-1:0] pend_nx;
	logic [19:0]      supp;
	logic             emit;
	logic             pair;
	result_t          first_res;
	result_t          second_res;
	logic [CodeW-1:0] partial_d;
	logic [PendW-1:0] pend_d;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !hold_valid_q && out_free;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		lead = decode_lead(text_byte);
		if (pend_q == '0) begin
			code_nx = lead.code;
			pend_nx = lead.pend;
		end else begin
			code_nx = {partial_q[CodeW-7:0], text_byte[5:0]};
			pend_nx = pend_q - PendW'(1);
		end
		supp       = code_nx[19:0] - SuppOffset;
		emit       = 1'b0;
		pair       = 1'b0;
		first_res  = '0;
		second_res = '0;
		partial_d  = code_nx;
		pend_d     = pend_nx;
		if (pend_nx != '0) begin
			if (end_of_text) begin
				emit            = 1'b1;
				first_res.last  = 1'b1;
				first_res.done  = 1'b1;
				first_res.trunc = 1'b1;
				partial_d       = '0;
				pend_d          = '0;
			end
		end else begin
			emit      = 1'b1;
			partial_d = '0;
			if (code_nx[CodeW-1:UnitW] == '0) begin
				first_res.unit = code_nx[UnitW-1:0];
				first_res.last = 1'b1;
				first_res.done = end_of_text;
			end else begin
				pair            = 1'b1;
				first_res.unit  = HiSurrBase | {6'd0, supp[19:10]};
				second_res.unit = LoSurrBase | {6'd0, supp[9:0]};
				second_res.last = 1'b1;
				second_res.done = end_of_text;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q    <= '0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				partial_q <= partial_d;
				pend_q    <= pend_d;
			end
			if (in_fire) begin
				out_valid_q  <= emit;
				hold_valid_q <= pair;
			end else if (out_free) begin
				out_valid_q  <= hold_valid_q;
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q  <= first_res;
			hold_q <= second_res;
		end else if (out_free && hold_valid_q) begin
			out_q <= hold_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_unit   = out_q.unit;
	assign last_of_run = out_q.last;
	assign text_done   = out_q.done;
	assign truncated   = out_q.trunc;

	a_hold_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> out_valid_q)
		else $error("second unit pending without a first");

	a_high_half_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last) |-> hold_valid_q)
		else $error("high surrogate without low half queued");

	a_trunc_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.trunc) |->
		(out_q.unit == '0 && out_q.last && out_q.done))
		else $error("malformed truncation result");

	a_pair_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_valid_q && out_ready) |=> (out_valid_q && !hold_valid_q && out_q.last))
		else $error("low surrogate not moved to output");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for utf8_to_utf16_transcoder_unit: byte-level stimulus, in-line transcoder
// prediction and per-unit checking of code_unit, last_of_run, text_done and truncated.
// Depends on u8u16_pkg (result_t) and the transcoder RTL.
module tb_top;
	import u8u16_pkg::*;

	localparam int WATCHDOG_LIMIT = 500;
	localparam int RANDOM_BYTES   = 1350;
	localparam int TOTAL_BYTES    = 1550;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [7:0]       text_byte;
	logic             end_of_text;
	logic             out_valid;
	logic             out_ready;
	logic [UnitW-1:0] code_unit;
	logic             last_of_run;
	logic             text_done;
	logic             truncated;

	utf8_to_utf16_transcoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_unit   (code_unit),
		.last_of_run (last_of_run),
		.text_done   (text_done),
		.truncated   (truncated)
	);

	// transcoder state mirror
	logic [30:0] acc_code;
	logic [2:0]  cont_left;
	result_t     units_due[$];
	result_t     due;

	logic [7:0]  text_q[$];
	bit          idle_en;
	int          n_errors;
	int          n_bytes;
	int          n_texts;
	int          n_units;
	int          n_pairs;
	int          n_cut;
	int          quiet_cycles = 0;
	int          stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void queue_unit(input result_t r);
		units_due.insert(units_due.size(), r);
	endfunction

	function automatic void queue_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	function automatic void transcode_byte(input logic [7:0] b, input logic eot);
		logic [30:0] cp;
		logic [30:0] diff;
		if (cont_left == 3'd0) begin
			acc_code = '0;
			if (b[7] == 1'b0) begin
				acc_code[6:0] = b[6:0];
				cont_left     = 3'd0;
			end else if (b[7:5] == 3'b110) begin
				acc_code[4:0] = b[4:0];
				cont_left     = 3'd1;
			end else if (b[7:4] == 4'b1110) begin
				acc_code[3:0] = b[3:0];
				cont_left     = 3'd2;
			end else if (b[7:3] == 5'b11110) begin
				acc_code[2:0] = b[2:0];
				cont_left     = 3'd3;
			end else if (b[7:2] == 6'b111110) begin
				acc_code[1:0] = b[1:0];
				cont_left     = 3'd4;
			end else begin
				acc_code[0] = b[0];
				cont_left   = 3'd5;
			end
		end else begin
			acc_code  = {acc_code[24:0], b[5:0]};
			cont_left = cont_left - 3'd1;
		end
		if (cont_left != 3'd0) begin
			if (eot) begin
				queue_unit('{unit: '0, last: 1'b1, done: 1'b1, trunc: 1'b1});
				acc_code  = '0;
				cont_left = '0;
				n_cut++;
			end
			return;
		end
		cp       = acc_code;
		acc_code = '0;
		if (cp < 31'h10000) begin
			queue_unit('{unit: cp[15:0], last: 1'b1, done: eot, trunc: 1'b0});
		end else begin
			diff = cp - 31'h10000;
			queue_unit('{unit: 16'hD800 + {6'd0, diff[19:10]},
				last: 1'b0, done: 1'b0, trunc: 1'b0});
			queue_unit('{unit: 16'hDC00 + {6'd0, diff[9:0]},
				last: 1'b1, done: eot, trunc: 1'b0});
			n_pairs++;
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (n_errors < 30)
			$display("mismatch at unit %0d: %s got 0x%0h want 0x%0h", n_units, what, got, want);
		n_errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (units_due.size() == 0) begin
				report_mismatch("unexpected unit", code_unit, 0);
			end else begin
				due = units_due.pop_front();
				if (code_unit !== due.unit) report_mismatch("code_unit", code_unit, due.unit);
				if (last_of_run !== due.last) report_mismatch("last_of_run", last_of_run, due.last);
				if (text_done !== due.done) report_mismatch("text_done", text_done, due.done);
				if (truncated !== due.trunc) report_mismatch("truncated", truncated, due.trunc);
			end
			n_units++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d units outstanding",
				quiet_cycles, units_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver with random stall bursts
	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 6) == 0) begin
				out_ready  <= 1'b0;
				stall_left = $urandom_range(1, 9) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// entered and left at a falling edge; valid stays high across back-to-back requests
	task automatic send_byte(input logic [7:0] b, input logic eot);
		int gap;
		gap = 0;
		if (idle_en && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_byte   <= b;
		end_of_text <= eot;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		transcode_byte(b, eot);
		n_bytes++;
		@(negedge clk);
	endtask

	task automatic send_text();
		int i;
		for (i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		n_texts++;
	endtask

	function automatic logic [7:0] cont_byte();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom);
		return {2'b10, 6'($urandom)};
	endfunction

	function automatic void append_char(input int form);
		logic [7:0] lead;
		int         i;
		case (form)
			1: lead = {1'b0, 7'($urandom)};
			2: lead = {3'b110, 5'($urandom)};
			3: lead = {4'b1110, 4'($urandom)};
			4: lead = {5'b11110, 3'($urandom)};
			5: lead = {6'b111110, 2'($urandom)};
			default: lead = $urandom_range(0, 1) ? {2'b10, 6'($urandom)}
				: {6'b111111, 2'($urandom)};
		endcase
		queue_byte(lead);
		for (i = 1; i < form; i++)
			queue_byte(cont_byte());
	endfunction

	task automatic test_ascii();
		text_q = '{8'h00, 8'h7F};
		send_text();
	endtask

	task automatic test_multibyte();
		// continuation without the 10 prefix, then the largest single unit
		text_q = '{8'hDF, 8'h3F, 8'hEF, 8'hBF, 8'hBF};
		send_text();
	endtask

	task automatic test_surrogates();
		text_q = '{8'hF0, 8'h90, 8'h80, 8'h80};
		send_text();
	endtask

	task automatic test_long_forms();
		text_q = '{8'hFF, 8'hC0, 8'hC0, 8'hC0, 8'hC0, 8'hC0};
		send_text();
		text_q = '{8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
		send_text();
	endtask

	task automatic test_stray_and_truncation();
		text_q = '{8'h80};
		send_text();
		text_q = '{8'hE2, 8'h82};
		send_text();
	endtask

	task automatic random_text(input int max_chars);
		int n;
		int k;
		int r;
		int f;
		text_q.delete();
		n = $urandom_range(1, max_chars);
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				queue_byte(8'($urandom));
			else if (r < 40)
				append_char(1);
			else if (r < 56)
				append_char(2);
			else if (r < 70)
				append_char(3);
			else if (r < 88)
				append_char(4);
			else if (r < 94)
				append_char(5);
			else
				append_char(6);
		end
		if ($urandom_range(0, 9) == 0) begin
			f = $urandom_range(2, 6);
			append_char(f);
			repeat ($urandom_range(1, f - 1)) void'(text_q.pop_back());
		end
		send_text();
	endtask

	task automatic test_random_text();
		while (n_bytes < RANDOM_BYTES) begin
			idle_en = ($urandom_range(0, 5) != 0);
			random_text(12);
		end
	endtask

	task automatic test_steady_stream();
		idle_en = 1'b0;
		while (n_bytes < TOTAL_BYTES)
			random_text(12);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		text_byte   = '0;
		end_of_text = 1'b0;
		idle_en     = 1'b1;
		acc_code    = '0;
		cont_left   = '0;
		n_errors    = 0;
		n_bytes     = 0;
		n_texts     = 0;
		n_units     = 0;
		n_pairs     = 0;
		n_cut       = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_ascii();
		test_multibyte();
		test_surrogates();
		test_long_forms();
		test_stray_and_truncation();
		test_random_text();
		test_steady_stream();

		in_valid <= 1'b0;
		while (units_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d bytes in %0d texts; checked %0d units", n_bytes, n_texts, n_units);
		$display("%0d surrogate pairs, %0d truncated texts, %0d mismatches",
			n_pairs, n_cut, n_errors);
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
